/* sv/smp_pkg.sv */
// Shared types, constants and helpers for the streaming max pooling block.
package smp_pkg;

  localparam int SampleW     = 16;
  localparam int MaxWidthDef = 1024;
  localparam int MaxStride   = 8;
  localparam int MaxHeight   = 1024;
  localparam int MaxChannels = 512;
  localparam int RecipShift  = 16;
  localparam int RecipW      = RecipShift + 1;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 11;

  localparam logic [3:0]  StrideRst   = 4'd2;
  localparam logic [10:0] InWidthRst  = 11'd32;
  localparam logic [10:0] InHeightRst = 11'd32;
  localparam logic [9:0]  ChannelsRst = 10'd1;

  // Start value of a running maximum: most negative Q8.8 code.
  localparam logic signed [SampleW-1:0] MostNegative = 16'sh8000;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_STRIDE    = 2'd0,
    CFG_IN_WIDTH  = 2'd1,
    CFG_IN_HEIGHT = 2'd2,
    CFG_CHANNELS  = 2'd3
  } cfg_idx_t;

  // Where the current sample sits inside its window and frame.
  typedef struct packed {
    logic phase_zero;    // first column of a window row
    logic row_phase_nz;  // not the first row of a window
    logic win_col_end;   // last column of a window row
    logic win_row_end;   // last row of a window
    logic frame_last;    // last sample of the last channel
  } pos_t;

  // ceil(2^16 / s) for s = 1..8; floor(n * recip >> 16) == n / s for n < 8192.
  function automatic logic [RecipW-1:0] recip(input logic [3:0] s);
    logic [RecipW-1:0] r;
    case (s)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

/* sv/smp_cfg_regs.sv */
// Configuration registers with range clamping of the effective values.
module smp_cfg_regs #(
  parameter int MAX_WIDTH = smp_pkg::MaxWidthDef,
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [smp_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [smp_pkg::CfgDataW-1:0]  cfg_data,
  output logic [3:0]                    stride_eff,
  output logic [WW-1:0]                 width_eff,
  output logic [10:0]                   height_eff,
  output logic [9:0]                    chan_eff
);

  localparam int WCW = (WW > 11) ? WW : 11;

  logic [3:0]  stride_r;
  logic [10:0] in_width_r;
  logic [10:0] in_height_r;
  logic [9:0]  channels_r;
  logic [WCW-1:0] width_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r    <= smp_pkg::StrideRst;
      in_width_r  <= smp_pkg::InWidthRst;
      in_height_r <= smp_pkg::InHeightRst;
      channels_r  <= smp_pkg::ChannelsRst;
    end else if (cfg_we) begin
      case (smp_pkg::cfg_idx_t'(cfg_index))
        smp_pkg::CFG_STRIDE:    stride_r    <= cfg_data[3:0];
        smp_pkg::CFG_IN_WIDTH:  in_width_r  <= cfg_data[10:0];
        smp_pkg::CFG_IN_HEIGHT: in_height_r <= cfg_data[10:0];
        smp_pkg::CFG_CHANNELS:  channels_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign width_ext = WCW'(in_width_r);

  // Zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (stride_r == 4'd0)                     stride_eff = 4'd1;
    else if (stride_r > 4'(smp_pkg::MaxStride)) stride_eff = 4'(smp_pkg::MaxStride);
    else                                      stride_eff = stride_r;

    if (in_width_r == 11'd0)                  width_eff = WW'(1);
    else if (width_ext > WCW'(MAX_WIDTH))     width_eff = WW'(MAX_WIDTH);
    else                                      width_eff = WW'(width_ext);

    if (in_height_r == 11'd0)                 height_eff = 11'd1;
    else if (in_height_r > 11'(smp_pkg::MaxHeight)) height_eff = 11'(smp_pkg::MaxHeight);
    else                                      height_eff = in_height_r;

    if (channels_r == 10'd0)                  chan_eff = 10'd1;
    else if (channels_r > 10'(smp_pkg::MaxChannels)) chan_eff = 10'(smp_pkg::MaxChannels);
    else                                      chan_eff = channels_r;
  end

endmodule

/* sv/smp_scan.sv */
// Raster position counters, window phases and line store column address.
module smp_scan #(
  parameter int MAX_WIDTH = smp_pkg::MaxWidthDef,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic [3:0]    stride_eff,
  input  logic [WW-1:0] width_eff,
  input  logic [10:0]   height_eff,
  input  logic [9:0]    chan_eff,
  output smp_pkg::pos_t pos,
  output logic [CW-1:0] out_col
);

  localparam int PW = CW + smp_pkg::RecipW;

  logic [CW-1:0] col_r, col_nxt;
  logic [9:0]    row_r, row_nxt;
  logic [8:0]    chan_r, chan_nxt;
  logic [2:0]    cph_r, cph_nxt;
  logic [2:0]    rph_r, rph_nxt;
  logic          col_last, row_last, chan_last, wce, wre;
  logic [PW-1:0] prod;

  assign col_last  = ((CW+1)'(col_r) + (CW+1)'(1)) >= (CW+1)'(width_eff);
  assign row_last  = (11'(row_r) + 11'd1) >= height_eff;
  assign chan_last = (10'(chan_r) + 10'd1) >= chan_eff;
  assign wce = ((4'(cph_r) + 4'd1) >= stride_eff) || col_last;
  assign wre = ((4'(rph_r) + 4'd1) >= stride_eff) || row_last;

  assign pos.phase_zero   = (cph_r == 3'd0);
  assign pos.row_phase_nz = (rph_r != 3'd0);
  assign pos.win_col_end  = wce;
  assign pos.win_row_end  = wre;
  assign pos.frame_last   = col_last && row_last && chan_last;

  // Output column = column / stride, by reciprocal multiply.
  assign prod    = PW'(col_r) * PW'(smp_pkg::recip(stride_eff));
  assign out_col = prod[smp_pkg::RecipShift +: CW];

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    chan_nxt = chan_r;
    cph_nxt  = cph_r;
    rph_nxt  = rph_r;
    if (col_last) begin
      col_nxt = '0;
      cph_nxt = '0;
      rph_nxt = wre ? 3'd0 : rph_r + 3'd1;
      if (row_last) begin
        row_nxt  = '0;
        rph_nxt  = '0;
        chan_nxt = chan_last ? 9'd0 : chan_r + 9'd1;
      end else begin
        row_nxt = row_r + 10'd1;
      end
    end else begin
      col_nxt = col_r + CW'(1);
      cph_nxt = wce ? 3'd0 : cph_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      chan_r <= '0;
      cph_r  <= '0;
      rph_r  <= '0;
    end else if (advance) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      chan_r <= chan_nxt;
      cph_r  <= cph_nxt;
      rph_r  <= rph_nxt;
    end
  end

endmodule

/* sv/smp_line_store.sv */
// Per output column partial maxima: one write and one registered read a cycle.
module smp_line_store #(
  parameter int MAX_WIDTH = smp_pkg::MaxWidthDef,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [CW-1:0]                       rd_addr,
  input  logic                                wr_en,
  input  logic [CW-1:0]                       wr_addr,
  input  logic signed [smp_pkg::SampleW-1:0]  wr_data,
  output logic signed [smp_pkg::SampleW-1:0]  rd_data
);

  logic signed [smp_pkg::SampleW-1:0] mem [MAX_WIDTH];
  logic signed [smp_pkg::SampleW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Pass a same-cycle write through to the read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) rd_data_r <= wr_data;
      else                               rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/streaming_max_pool_2d_unit.sv */
// Top level of the streaming 2-D max pooling unit.
//
//  channel | handshake          | payload                              | dir
//  --------+--------------------+--------------------------------------+----
//  in      | in_valid/in_ready  | in_sample (s16 Q8.8)                 | in
//  out     | out_valid/out_ready| out_pooled_value (s16), out_last_of_frame | out
//  cfg     | cfg_valid/cfg_ready| cfg_index (2), cfg_data (11)         | in
//
// One word per clock sustained on the input while the output is not stalled.
// A word is captured into the stage register together with its window
// position and the line store read; when the stage fires, the window maximum
// is formed and lands in the output register.
// Synchronous active-low reset returns counters and configuration to their
// defaults; the line store is not cleared. A stalled output holds the stage
// register, and the input then waits; cfg_ready is always high.
module streaming_max_pool_2d_unit #(
  parameter int MAX_WIDTH = smp_pkg::MaxWidthDef
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [smp_pkg::SampleW-1:0]  in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [smp_pkg::SampleW-1:0]  out_pooled_value,
  output logic                                out_last_of_frame,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smp_pkg::CfgIndexW-1:0]       cfg_index,
  input  logic [smp_pkg::CfgDataW-1:0]        cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);

  logic [3:0]    stride_eff;
  logic [WW-1:0] width_eff;
  logic [10:0]   height_eff;
  logic [9:0]    chan_eff;

  smp_pkg::pos_t pos;
  logic [CW-1:0] out_col;

  logic in_accept;
  logic stage_free;
  logic s1_fire;

  // Stage register: sample plus its position, captured on accept.
  logic                               s1_valid_r;
  logic signed [smp_pkg::SampleW-1:0] s1_sample_r;
  smp_pkg::pos_t                      s1_pos_r;
  logic [CW-1:0]                      s1_col_r;

  logic signed [smp_pkg::SampleW-1:0] rrm_r, rrm_nxt;
  logic signed [smp_pkg::SampleW-1:0] line_rd;
  logic signed [smp_pkg::SampleW-1:0] win_max;
  logic                               line_we;
  logic                               res_load;

  logic                               out_valid_r;
  logic signed [smp_pkg::SampleW-1:0] out_value_r;
  logic                               out_last_r;

  assign cfg_ready = 1'b1;

  smp_cfg_regs #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .stride_eff (stride_eff),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .chan_eff   (chan_eff)
  );

  // Advance the position counters once per accepted word.
  smp_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (in_accept),
    .stride_eff (stride_eff),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .chan_eff   (chan_eff),
    .pos        (pos),
    .out_col    (out_col)
  );

  smp_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (out_col),
    .wr_en   (line_we),
    .wr_addr (s1_col_r),
    .wr_data (win_max),
    .rd_data (line_rd)
  );

  // Handshake: the stage drains whenever the output register can take a word.
  assign stage_free = !out_valid_r || out_ready;
  assign s1_fire    = s1_valid_r && stage_free;
  assign in_ready   = !s1_valid_r || stage_free;
  assign in_accept  = in_valid && in_ready;

  // Restart the row maximum on the first column of a window.
  always_comb begin
    if (s1_pos_r.phase_zero || (s1_sample_r > rrm_r)) rrm_nxt = s1_sample_r;
    else                                               rrm_nxt = rrm_r;
    win_max = rrm_nxt;
    if (s1_pos_r.row_phase_nz && (line_rd > rrm_nxt)) win_max = line_rd;
  end

  // Keep the partial maximum until the window's bottom row, then emit.
  assign line_we  = s1_fire && s1_pos_r.win_col_end && !s1_pos_r.win_row_end;
  assign res_load = s1_fire && s1_pos_r.win_col_end && s1_pos_r.win_row_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample_r <= in_sample;
      s1_pos_r    <= pos;
      s1_col_r    <= out_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rrm_r <= smp_pkg::MostNegative;
    end else if (s1_fire) begin
      rrm_r <= rrm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_value_r <= win_max;
      out_last_r  <= s1_pos_r.frame_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pooled_value  = out_value_r;
  assign out_last_of_frame = out_last_r;

endmodule

/* sv/smp_checker.sv */
// Port-level checks for the max pooling unit, bound to the top level.
module smp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [smp_pkg::SampleW-1:0]  out_pooled_value,
  input logic                                out_last_of_frame,
  input logic                                cfg_ready
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pooled_value)
      && $stable(out_last_of_frame))
    else $error("stalled result word changed");

  // Drop any result in flight on reset.
  a_out_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // An empty output register never blocks the input.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Configuration words are always taken.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind streaming_max_pool_2d_unit smp_checker u_smp_checker (.*);

/* sim/tb.sv */
// Self-checking testbench for the streaming 2-D max pooling unit.
typedef struct {
  logic signed [smp_pkg::SampleW-1:0] value;
  logic                               last;
} pooled_t;

class max_pool_scoreboard;
  logic [3:0]                         stride_reg;
  logic [10:0]                        width_reg;
  logic [10:0]                        height_reg;
  logic [9:0]                         chan_reg;
  int unsigned                        col, row, chan, col_ph, row_ph;
  logic signed [smp_pkg::SampleW-1:0] row_max;
  logic signed [smp_pkg::SampleW-1:0] line_max [smp_pkg::MaxWidthDef];
  pooled_t                            pooled_due[$];
  int                                 mismatch_count;

  function new();
    stride_reg = smp_pkg::StrideRst;
    width_reg = smp_pkg::InWidthRst;
    height_reg = smp_pkg::InHeightRst;
    chan_reg = smp_pkg::ChannelsRst;
    col = 0;
    row = 0;
    chan = 0;
    col_ph = 0;
    row_ph = 0;
    row_max = smp_pkg::MostNegative;
    foreach (line_max[i]) line_max[i] = '0;
    mismatch_count = 0;
  endfunction

  // Out-of-range settings: zero acts as one, too large acts as the maximum.
  function int unsigned fit(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function void write_reg(smp_pkg::cfg_idx_t idx, logic [smp_pkg::CfgDataW-1:0] d);
    case (idx)
      smp_pkg::CFG_STRIDE:    stride_reg = d[3:0];
      smp_pkg::CFG_IN_WIDTH:  width_reg = d;
      smp_pkg::CFG_IN_HEIGHT: height_reg = d;
      smp_pkg::CFG_CHANNELS:  chan_reg = d[9:0];
      default: ;
    endcase
  endfunction

  function int unsigned frame_words();
    return fit(width_reg, smp_pkg::MaxWidthDef) * fit(height_reg, smp_pkg::MaxHeight) *
           fit(chan_reg, smp_pkg::MaxChannels);
  endfunction

  // Advance the window position by one sample; queue a maximum when a window closes.
  function void take_sample(logic signed [smp_pkg::SampleW-1:0] x);
    int unsigned                        s, w, h, c, oc;
    bit                                 col_last, row_last, chan_last, wc_end, wr_end;
    logic signed [smp_pkg::SampleW-1:0] m;
    pooled_t                            p;
    s = fit(stride_reg, smp_pkg::MaxStride);
    w = fit(width_reg, smp_pkg::MaxWidthDef);
    h = fit(height_reg, smp_pkg::MaxHeight);
    c = fit(chan_reg, smp_pkg::MaxChannels);
    col_last = col + 1 >= w;
    row_last = row + 1 >= h;
    chan_last = chan + 1 >= c;
    wc_end = (col_ph + 1 >= s) || col_last;
    wr_end = (row_ph + 1 >= s) || row_last;
    oc = col / s;
    if (oc >= smp_pkg::MaxWidthDef) oc = smp_pkg::MaxWidthDef - 1;

    if (col_ph == 0 || x > row_max) row_max = x;

    if (wc_end) begin
      m = row_max;
      if (row_ph != 0 && line_max[oc] > m) m = line_max[oc];
      if (wr_end) begin
        p.value = m;
        p.last = col_last && row_last && chan_last;
        pooled_due.push_back(p);
      end else begin
        line_max[oc] = m;
      end
      col_ph = 0;
    end else begin
      col_ph++;
    end

    if (col_last) begin
      col = 0;
      col_ph = 0;
      if (wr_end) row_ph = 0;
      else row_ph++;
      if (row_last) begin
        row = 0;
        row_ph = 0;
        chan = chan_last ? 0 : chan + 1;
      end else begin
        row++;
      end
    end else begin
      col++;
    end
  endfunction

  function void check_pooled(logic signed [smp_pkg::SampleW-1:0] v, logic last);
    pooled_t e;
    if (pooled_due.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected word: pooled %0d last %0b, nothing due", v, last);
      return;
    end
    e = pooled_due.pop_front();
    if (v !== e.value || last !== e.last) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("pooled %0d last %0b, expected pooled %0d last %0b",
                 v, last, e.value, e.last);
    end
  endfunction
endclass

module tb;
  localparam int SampleW      = smp_pkg::SampleW;
  localparam int CfgDataW     = smp_pkg::CfgDataW;
  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 8;     // pipeline is two deep; leave margin
  localparam int HoldAt       = 200;   // result count that starts the long stall
  localparam int HoldCycles   = 300;
  localparam int RandomWords  = 260;

  // Corner frame: stride 2 over 3x3, so the right column and the bottom row
  // form partial windows. The first window holds only the most negative code.
  localparam logic signed [SampleW-1:0] CornerWords [9] = '{
    16'sh8000, 16'sh8000, 16'sh7FFF,
    16'sh8000, 16'sh8000, -16'sd1,
    16'sd0,    16'sd1,    -16'sd256
  };

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [SampleW-1:0] in_sample = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [SampleW-1:0] out_pooled_value;
  logic                      out_last_of_frame;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  smp_pkg::cfg_idx_t         cfg_index = smp_pkg::CFG_STRIDE;
  logic [CfgDataW-1:0]       cfg_data = '0;

  int in_calm = 0;
  int out_calm = 0;
  int results_seen = 0;
  int cycles = 0;
  bit held = 1'b0;

  max_pool_scoreboard sb = new();

  streaming_max_pool_2d_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pooled_value  (out_pooled_value),
    .out_last_of_frame (out_last_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Draw a random idle gap before the next word, with occasional runs of
  // back-to-back words.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 3);
  endfunction

  // Mix full-range samples with the extremes and clusters of near-equal values.
  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return smp_pkg::MostNegative;
      1:       return 16'sh7FFF;
      2:       return SampleW'($urandom_range(0, 8) - 4);
      3:       return smp_pkg::MostNegative + SampleW'($urandom_range(0, 3));
      default: return SampleW'($urandom);
    endcase
  endfunction

  // Keep random frames small; now and then zero or a wider extent.
  function automatic logic [10:0] pick_extent();
    case ($urandom_range(0, 15))
      0:       return 11'd0;
      1:       return 11'($urandom_range(11, 20));
      default: return 11'($urandom_range(1, 10));
    endcase
  endfunction

  // Offer one sample word; hold valid and payload until accepted. Valid stays
  // high on return so a back-to-back word needs no second assignment.
  task automatic send_sample(input logic signed [SampleW-1:0] v);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_words(input int n);
    for (int i = 0; i < n; i++) send_sample(pick_sample());
  endtask

  // Drop valid, wait for every due result, then let the pipeline drain words
  // that close no window.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pooled_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write one register; keep valid high when another write follows at once.
  task automatic cfg_write(input smp_pkg::cfg_idx_t idx, input logic [CfgDataW-1:0] d,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, d);
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [CfgDataW-1:0] s, input logic [CfgDataW-1:0] w,
                            input logic [CfgDataW-1:0] h, input logic [CfgDataW-1:0] c);
    settle();
    cfg_write(smp_pkg::CFG_STRIDE, s, 1'b1);
    cfg_write(smp_pkg::CFG_IN_WIDTH, w, 1'b1);
    cfg_write(smp_pkg::CFG_IN_HEIGHT, h, 1'b1);
    cfg_write(smp_pkg::CFG_CHANNELS, c, 1'b0);
  endtask

  // Watch both data channels at each edge; values read here are pre-edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_sample(in_sample);
      if (out_valid && out_ready) begin
        sb.check_pooled(out_pooled_value, out_last_of_frame);
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("streaming_max_pool_2d_unit: mismatch");
      $finish;
    end
  end

  // Result side: random stalls per word, plus one long hold-off once enough
  // results have passed, while the sender keeps offering words.
  initial begin : drain
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap(out_calm);
      if (!held && results_seen >= HoldAt) begin
        held = 1'b1;
        gap = HoldCycles;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned         sent;
    int unsigned         n;
    int unsigned         s;
    logic [10:0]         w, h;
    logic [CfgDataW-1:0] sdat, cdat;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings (stride 2, 32x32, one channel): two rows, then cut the
    // frame short by lowering the height mid-frame at a window-row boundary.
    send_words(64);
    settle();
    cfg_write(smp_pkg::CFG_IN_HEIGHT, 11'd2, 1'b0);
    send_words(32);

    // Partial windows at the right and bottom, extreme sample codes.
    set_config(11'd2, 11'd3, 11'd3, 11'd1);
    foreach (CornerWords[i]) send_sample(CornerWords[i]);

    // All-zero settings act as ones: every word is a whole frame.
    set_config(11'd0, 11'd0, 11'd0, 11'd0);
    send_sample(16'sh7FFF);
    send_sample(smp_pkg::MostNegative);

    // Stride above range (upper data bits set too), two channels.
    set_config(11'h7FF, 11'd3, 11'd2, 11'h402);
    send_words(12);

    // Channel count written above range acts as the largest; one frame.
    set_config(11'd1, 11'd1, 11'd1, 11'h3FF);
    send_words(sb.frame_words());

    // Channel count lowered below the current channel mid-frame: that channel
    // becomes the last one.
    set_config(11'd2, 11'd2, 11'd2, 11'd5);
    send_words(8);
    settle();
    cfg_write(smp_pkg::CFG_CHANNELS, 11'd1, 1'b0);
    send_words(4);

    // Random settings, whole frames only, so every frame starts from a clean
    // window position.
    sent = 0;
    while (sent < RandomWords) begin
      case ($urandom_range(0, 9))
        0:       s = $urandom_range(9, 15);
        1:       s = 0;
        default: s = $urandom_range(1, 8);
      endcase
      sdat = 11'(($urandom_range(0, 127) << 4) | s);
      w = pick_extent();
      h = pick_extent();
      cdat = (w * h > 40) ? 11'd1 : 11'($urandom_range(0, 3));
      cdat[10] = 1'($urandom_range(0, 1));
      set_config(sdat, w, h, cdat);
      n = sb.frame_words() * $urandom_range(1, 2);
      send_words(n);
      sent += n;
    end

    in_valid <= 1'b0;
    while (sb.pooled_due.size() != 0) @(posedge clk);
    repeat (SettleCycles * 2) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pooled_due.size() == 0)
      $display("streaming_max_pool_2d_unit: match");
    else
      $display("streaming_max_pool_2d_unit: mismatch");
    $finish;
  end
endmodule
